>>> sv/smh_pkg.sv
// ----------------------------------------------------------------------------
// smh_pkg
// shared types and constants of the sparse histogram core
// ----------------------------------------------------------------------------
package smh_pkg;

  localparam int BUCKET_W = 16;
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 32;
  localparam int CFG_W    = 64;
  localparam int DIMS_MAX = 4;

  localparam logic signed [BUCKET_W-1:0] BUCKET_TOP = 16'sd32767;
  localparam logic [CFG_W-1:0] CFG_RESET = 64'h0001_0001_0000_0000;

  localparam logic [1:0] ST_COUNTED = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNUSED  = 2'd3;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request beat
    logic div_start;  // start division of current dimension
    logic div_step;   // one quotient bit
    logic div_done;   // write bucket of current dimension
    logic dim_next;   // advance dimension
    logic scan_rd;    // issue memory read at scan pointer
    logic scan_next;  // advance scan pointer
    logic hit_wr;     // write incremented count at scan pointer
    logic new_wr;     // append new entry
    logic rd_issue;   // issue read of requested entry
    logic res_hit;
    logic res_new;
    logic res_full;
    logic res_read;
    logic res_unused;
  } smh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic read_ok;
    logic last_dim;
    logic div_last;
    logic scan_end;
    logic key_match;
    logic table_full;
    logic out_free;
  } smh_sts_t;

endpackage

>>> sv/smh_ctrl.sv
// ----------------------------------------------------------------------------
// smh_ctrl
// sequencer: bucket division per dimension, table scan, update or read
// ----------------------------------------------------------------------------
module smh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  smh_pkg::smh_sts_t sts,
  output smh_pkg::smh_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DINIT = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_DFIN  = 10'b0000001000,
    S_SRD   = 10'b0000010000,
    S_SCMP  = 10'b0000100000,
    S_RRD   = 10'b0001000000,
    S_RWAIT = 10'b0010000000,
    S_WAIT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.is_read) begin
          if (sts.read_ok) begin
            cmd.rd_issue = 1'b1;
            state_next = S_RRD;
          end else if (sts.out_free) begin
            cmd.res_unused = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_DINIT;
        end
      end
      S_RRD: state_next = S_RWAIT;
      S_RWAIT: begin
        if (sts.out_free) begin
          cmd.res_read = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DINIT: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DFIN;
      end
      S_DFIN: begin
        cmd.div_done = 1'b1;
        if (sts.last_dim) begin
          state_next = S_SRD;
        end else begin
          cmd.dim_next = 1'b1;
          state_next = S_DINIT;
        end
      end
      S_SRD: begin
        if (sts.scan_end) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.key_match) begin
          if (sts.out_free) begin
            cmd.hit_wr = 1'b1;
            cmd.res_hit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
          state_next = S_SRD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          if (sts.table_full) begin
            cmd.res_full = 1'b1;
          end else begin
            cmd.new_wr = 1'b1;
            cmd.res_new = 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.res_hit, cmd.res_new, cmd.res_full, cmd.res_read, cmd.res_unused}) <= 1)
    else $error("more than one result in a cycle");
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.hit_wr || cmd.new_wr) |-> sts.out_free)
    else $error("table written while output busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_WAIT)
    else $error("load did not leave idle");
`endif

endmodule

>>> sv/smh_datapath.sv
// ----------------------------------------------------------------------------
// smh_datapath
// config registers, shift-subtract divider, entry tables, output register
// ----------------------------------------------------------------------------
module smh_datapath #(
  parameter int MAX_ENTRIES = 256,
  parameter int NUM_DIMS    = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [smh_pkg::CFG_W-1:0] cfg_data,
  input  logic [111:0]              in_data,
  input  logic                      in_type,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [111:0]              out_data,
  input  smh_pkg::smh_cmd_t         cmd,
  output smh_pkg::smh_sts_t         sts
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int UW = $clog2(MAX_ENTRIES + 1);
  localparam int DIFF_W = 25;
  localparam int DW = 5;

  logic [smh_pkg::CFG_W-1:0] dim_setting [smh_pkg::DIMS_MAX];
  logic        req_read;
  logic [7:0]  req_index;
  logic signed [smh_pkg::SAMPLE_W-1:0] sample [smh_pkg::DIMS_MAX];
  logic [1:0]  dim;
  logic [15:0] key [smh_pkg::DIMS_MAX];
  logic [UW-1:0] used;
  logic [UW-1:0] scan;
  logic [DIFF_W-1:0] rem;
  logic [DIFF_W-1:0] quo;
  logic [DIFF_W-1:0] num;
  logic [DW-1:0]     bitc;
  logic              neg;
  logic [63:0]  mem_key [MAX_ENTRIES];
  logic [31:0]  mem_cnt [MAX_ENTRIES];
  logic [63:0]  rd_key;
  logic [31:0]  rd_cnt;
  logic [63:0]  key_flat;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < smh_pkg::DIMS_MAX; i++) dim_setting[i] <= smh_pkg::CFG_RESET;
    end else if (cfg_we) begin
      dim_setting[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_read  <= in_type;
      req_index <= in_data[103:96];
      for (int i = 0; i < smh_pkg::DIMS_MAX; i++) sample[i] <= in_data[i*24 +: 24];
    end
  end

  // per dimension fields
  logic signed [23:0] lower;
  logic [23:0] step;
  logic [15:0] bcount;
  logic signed [15:0] top;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] mag;
  logic [DIFF_W:0] trial;
  logic signed [DIFF_W:0] qs;
  logic signed [15:0] bucket;

  always_comb begin
    lower  = dim_setting[dim][23:0];
    step   = dim_setting[dim][47:24];
    bcount = dim_setting[dim][63:48];
    top    = (bcount > 16'd32767) ? smh_pkg::BUCKET_TOP : signed'(bcount);
    diff   = DIFF_W'(sample[dim]) - DIFF_W'(lower);
    // ceil for negative: divide (|d| + step - 1)
    mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) + DIFF_W'(step) - DIFF_W'(1)
                            : DIFF_W'(diff);
    trial  = {rem[DIFF_W-2:0], num[DIFF_W-1]} - {2'b0, step};
    qs     = neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    if (step == 24'd0) bucket = neg ? -16'sd1 : top;
    else if (qs < -26'sd1) bucket = -16'sd1;
    else if (qs > 26'(top)) bucket = top;
    else bucket = qs[15:0];
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) dim <= '0;
    else if (cmd.dim_next) dim <= dim + 2'd1;
    if (cmd.div_start) begin
      num  <= mag;
      neg  <= diff[DIFF_W-1];
      rem  <= '0;
      quo  <= '0;
      bitc <= '0;
    end else if (cmd.div_step) begin
      num  <= {num[DIFF_W-2:0], 1'b0};
      bitc <= bitc + DW'(1);
      if (!trial[DIFF_W]) begin
        rem <= trial[DIFF_W-1:0];
        quo <= {quo[DIFF_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIFF_W-2:0], num[DIFF_W-1]};
        quo <= {quo[DIFF_W-2:0], 1'b0};
      end
    end
    if (cmd.load) begin
      for (int i = 0; i < smh_pkg::DIMS_MAX; i++) key[i] <= '0;
    end else if (cmd.div_done) begin
      key[dim] <= bucket;
    end
  end

  always_comb begin
    key_flat = {key[3], key[2], key[1], key[0]};
  end

  // table
  always_ff @(posedge clk) begin
    if (rst) used <= '0;
    else if (cmd.new_wr) used <= used + UW'(1);
    if (cmd.div_start) scan <= '0;
    else if (cmd.scan_next) scan <= scan + UW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.new_wr) begin
      mem_key[used[IW-1:0]] <= key_flat;
      mem_cnt[used[IW-1:0]] <= 32'd1;
    end else if (cmd.hit_wr && rd_cnt != 32'hFFFF_FFFF) begin
      mem_cnt[scan[IW-1:0]] <= rd_cnt + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_key <= mem_key[scan[IW-1:0]];
      rd_cnt <= mem_cnt[scan[IW-1:0]];
    end else if (cmd.rd_issue) begin
      rd_key <= mem_key[IW'(req_index)];
      rd_cnt <= mem_cnt[IW'(req_index)];
    end
  end

  logic [31:0] hit_next;
  assign hit_next = (rd_cnt == 32'hFFFF_FFFF) ? rd_cnt : rd_cnt + 32'd1;

  // output register; buckets of unused dimensions are zero in key and table
  logic res;
  assign res = cmd.res_hit | cmd.res_new | cmd.res_full | cmd.res_read | cmd.res_unused;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (res) begin
      out_data[111:106] <= '0;
      if (cmd.res_hit) begin
        out_data[105:0] <= {hit_next, key_flat, 8'(scan), smh_pkg::ST_COUNTED};
      end else if (cmd.res_new) begin
        out_data[105:0] <= {32'd1, key_flat, 8'(used), smh_pkg::ST_NEW};
      end else if (cmd.res_full) begin
        out_data[105:0] <= {32'd0, key_flat, 8'd0, smh_pkg::ST_FULL};
      end else if (cmd.res_read) begin
        out_data[105:0] <= {rd_cnt, rd_key, req_index, smh_pkg::ST_COUNTED};
      end else begin
        out_data[105:0] <= {32'd0, 64'd0, req_index, smh_pkg::ST_UNUSED};
      end
    end
  end

  always_comb begin
    sts = '0;
    sts.is_read    = req_read;
    sts.read_ok    = (32'(req_index) < 32'(used)) && (32'(req_index) < 32'(MAX_ENTRIES));
    sts.last_dim   = (32'(dim) == 32'(NUM_DIMS - 1));
    sts.div_last   = (bitc == DW'(DIFF_W - 1));
    sts.scan_end   = (scan >= used);
    sts.key_match  = 1'b1;
    for (int i = 0; i < NUM_DIMS; i++)
      if (rd_key[16*i +: 16] != key[i]) sts.key_match = 1'b0;
    sts.table_full = (used >= UW'(MAX_ENTRIES));
    sts.out_free   = !out_valid || out_ready;
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(MAX_ENTRIES)) else $error("fill count overflow");
  a_no_new_full: assert property (@(posedge clk) disable iff (rst)
    cmd.new_wr |-> !sts.table_full) else $error("append into full table");
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    used != $past(used) |-> $past(cmd.new_wr)) else $error("fill count moved");
`endif

endmodule

>>> sv/sparse_multidim_histogram_core.sv
// ----------------------------------------------------------------------------
// sparse_multidim_histogram_core
// sparse multi-dimensional histogram with bucket quantizer and entry table
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         request beat: type in tuser, samples and index in tdata
// m_axis    out        result beat: status, index, buckets, count
// cfg       in         dimension setting writes
// add: serial division per dimension, then a read and compare per stored entry
// scanned; read: a direct table read. the divider and one-port table set the rate.
// rst is synchronous; it clears fill count, config and handshake state.
// a stalled m_axis holds the sequencer before any table write.
module sparse_multidim_histogram_core #(
  parameter int MAX_ENTRIES = 256,
  parameter int NUM_DIMS    = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // sample_a, sample_b, sample_c, sample_d, read_index
  input  logic         s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata   // status, entry_index, bucket_a..d, hit_count
);

  smh_pkg::smh_cmd_t cmd;
  smh_pkg::smh_sts_t sts;

  smh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  smh_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .NUM_DIMS(NUM_DIMS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data({8'd0, s_axis_tdata}), .in_type(s_axis_tuser), .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid), .out_data(m_axis_tdata), .cmd(cmd), .sts(sts)
  );

endmodule
